@@ design/gdr_pkg.sv @@
// Package for the gyro heading dead-reckoning unit.
// Holds the sequencer state type, register indexes, compass codes and the sine table
// generator. Used by gdr_sine_lookup and gyro_heading_dead_reckoning_unit.
package gdr_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL_YAW,
    S_ADD_YAW,
    S_MAG,
    S_MUL_HI,
    S_MUL_LO,
    S_IP,
    S_MOD,
    S_HEAD,
    S_MUL_X,
    S_MUL_Y,
    S_POS_Y,
    S_DONE
  } gdr_state_t;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 24;

  localparam logic [CFG_INDEX_W-1:0] REG_TIME_STEP     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HEADING_GAIN  = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_DRIVE_STEP    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_START_X       = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_START_Y       = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_REPORT_PERIOD = 3'd5;

  localparam logic [15:0] TIME_STEP_RST     = 16'd655;
  localparam logic [15:0] HEADING_GAIN_RST  = 16'd4608;
  localparam logic [23:0] DRIVE_STEP_RST    = 24'd1966;
  localparam logic [15:0] START_X_RST       = 16'd320;
  localparam logic [15:0] START_Y_RST       = 16'd240;
  localparam logic [7:0]  REPORT_PERIOD_RST = 8'd10;

  localparam logic [2:0] COMPASS_N    = 3'd0;
  localparam logic [2:0] COMPASS_E    = 3'd1;
  localparam logic [2:0] COMPASS_S    = 3'd2;
  localparam logic [2:0] COMPASS_W    = 3'd3;
  localparam logic [2:0] COMPASS_NONE = 3'd4;

  localparam logic [8:0] DEG_45  = 9'd45;
  localparam logic [8:0] DEG_90  = 9'd90;
  localparam logic [8:0] DEG_135 = 9'd135;
  localparam logic [8:0] DEG_180 = 9'd180;
  localparam logic [8:0] DEG_225 = 9'd225;
  localparam logic [8:0] DEG_270 = 9'd270;
  localparam logic [8:0] DEG_315 = 9'd315;
  localparam logic [8:0] DEG_360 = 9'd360;

  // Shared multiplier operand widths.
  localparam int MUL_A_W = 33;
  localparam int MUL_B_W = 25;
  localparam int PROD_W  = MUL_A_W + MUL_B_W;

  // The integer heading product is below 2^48 and is reduced one byte per step.
  localparam int IP_W      = 48;
  localparam int IP_DIGITS = IP_W / 8;

  localparam logic [63:0] PI_Q60 = 64'h3243F6A8885A308D;

  // Sine of k degrees in Q.30 from an eight-term Taylor sum; evaluated at elaboration.
  function automatic logic [63:0] gdr_sine_q30(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] sum;
    int unsigned        n;
    x    = ((PI_Q60 / 64'd180) * 64'(k)) >> 30;
    x2   = (x * x) >> 30;
    term = x;
    sum  = signed'(x);
    for (n = 1; n <= 7; n++) begin
      term = ((term * x2) >> 30) / 64'((2 * n) * (2 * n + 1));
      if (n[0]) begin
        sum = sum - signed'(term);
      end else begin
        sum = sum + signed'(term);
      end
    end
    if (sum < 0) begin
      sum = 64'sd0;
    end
    return unsigned'(sum);
  endfunction

  // Folds a whole-degree angle 0..359 onto the first quadrant.
  function automatic logic [6:0] gdr_fold(input logic [8:0] a);
    logic [8:0] f;
    priority if (a <= DEG_90) begin
      f = a;
    end else if (a <= DEG_180) begin
      f = DEG_180 - a;
    end else if (a <= DEG_270) begin
      f = a - DEG_180;
    end else begin
      f = DEG_360 - a;
    end
    return f[6:0];
  endfunction

endpackage

@@ design/gyro_heading_dead_reckoning_unit.sv @@
// Gyro heading and dead-reckoning position unit, top level.
// Instantiates gdr_sine_lookup and depends on gdr_pkg.
//
// Usage:
// Each input word is one sample tick carrying the signed z rate and a drive flag.
// The unit integrates yaw, derives a heading of 0..359 degrees, moves the position
// along the heading on driving ticks and raises a compass report every report period.
// One result word leaves per input word on the out_ channel.
// in_tready is high only in the idle step, so a new word is not taken until the last one
// has left the final step. The pace is set by the single shared 33x25 multiplier (five
// products per tick) and by the mod-360 reduction of the heading product, one byte per
// cycle over its six bytes.
// The result sits in an output register; the next word is accepted while it waits.
// If the receiver stalls, a finished word waits in its last step until the output
// register is free, and no input word is accepted meanwhile.
// Reset loads the register defaults, clears yaw and the tick count and loads the
// position from the start registers. Writes to the start registers reload the position.
// Configuration is written while the unit is idle.
module gyro_heading_dead_reckoning_unit import gdr_pkg::*; #(
  parameter int YAW_WIDTH      = 48,
  parameter int POS_WIDTH      = 40,
  parameter int SINE_FRAC_BITS = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   cfg_wen,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_wdata,
  input  logic                   in_tvalid,
  output logic                   in_tready,
  // Fields from bit 0: gyro_z_rate[15:0], driving[16], zero fill.
  input  logic [23:0]            in_tdata,
  output logic                   out_tvalid,
  input  logic                   out_tready,
  // Fields from bit 0: pos_x[15:0], pos_y[31:16], heading[40:32], compass[43:41], zero fill.
  output logic [47:0]            out_tdata,
  // Fields from bit 0: report[0].
  output logic                   out_tuser
);

  localparam int SINE_W  = SINE_FRAC_BITS + 1;
  localparam int YAW_EXT = (YAW_WIDTH > MUL_A_W ? YAW_WIDTH : MUL_A_W) + 1;
  localparam int POS_EXT = (POS_WIDTH > 33 ? POS_WIDTH : 33) + 1;
  localparam int STEP_W  = 26;

  function automatic logic signed [YAW_WIDTH-1:0] sat_yaw(input logic [YAW_EXT-1:0] s);
    logic [YAW_WIDTH-1:0] r;
    if (&s[YAW_EXT-1:YAW_WIDTH-1] || ~|s[YAW_EXT-1:YAW_WIDTH-1]) begin
      r = s[YAW_WIDTH-1:0];
    end else if (s[YAW_EXT-1]) begin
      r = {1'b1, {(YAW_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(YAW_WIDTH - 1){1'b1}}};
    end
    return signed'(r);
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] sat_pos(input logic [POS_EXT-1:0] s);
    logic [POS_WIDTH-1:0] r;
    if (&s[POS_EXT-1:POS_WIDTH-1] || ~|s[POS_EXT-1:POS_WIDTH-1]) begin
      r = s[POS_WIDTH-1:0];
    end else if (s[POS_EXT-1]) begin
      r = {1'b1, {(POS_WIDTH - 1){1'b0}}};
    end else begin
      r = {1'b0, {(POS_WIDTH - 1){1'b1}}};
    end
    return signed'(r);
  endfunction

  function automatic logic signed [POS_WIDTH-1:0] start_load(input logic [15:0] v);
    return sat_pos(POS_EXT'({v, 16'd0}));
  endfunction

  // Integer part truncated toward zero, saturated to 16 bits.
  function automatic logic [15:0] pos_out(input logic signed [POS_WIDTH-1:0] a);
    logic [POS_WIDTH-1:0] mag;
    logic [POS_WIDTH-1:0] q;
    logic [15:0]          r;
    mag = (a < 0) ? (POS_WIDTH'(0) - unsigned'(a)) : unsigned'(a);
    q   = mag >> 16;
    if (a < 0) begin
      r = (q > POS_WIDTH'(32768)) ? 16'h8000 : (16'd0 - q[15:0]);
    end else begin
      r = (q > POS_WIDTH'(32767)) ? 16'h7FFF : q[15:0];
    end
    return r;
  endfunction

  gdr_state_t state_r, state_nxt;

  logic [15:0] time_step_r;
  logic [15:0] heading_gain_r;
  logic [23:0] drive_step_r;
  logic [7:0]  report_period_r;

  logic signed [YAW_WIDTH-1:0] yaw_r;
  logic signed [POS_WIDTH-1:0] pos_x_r;
  logic signed [POS_WIDTH-1:0] pos_y_r;
  logic [7:0]                  tick_r;

  logic signed [15:0]        rate_r;
  logic                      drive_r;
  logic [63:0]               mag_r;
  logic [IP_W-1:0]           ip_r;
  logic [8:0]                rem_r;
  logic [2:0]                digit_r;
  logic [8:0]                heading_r;
  logic signed [PROD_W-1:0]  prod_r;

  logic        out_valid_r;
  logic [47:0] out_data_r;
  logic        out_user_r;

  logic signed [MUL_A_W-1:0] mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  mul_p;

  logic [SINE_W-1:0] mag_x;
  logic [SINE_W-1:0] mag_y;
  logic              neg_x;
  logic              neg_y;

  logic [YAW_EXT-1:0]        yaw_sum;
  logic [63:0]               yaw_abs;
  logic [16:0]               mod_v;
  logic [8:0]                heading_calc;
  logic [STEP_W-1:0]         step_mag;
  logic [POS_EXT-1:0]        step_ext;
  logic                      step_neg;
  logic signed [POS_WIDTH-1:0] pos_base;
  logic [POS_EXT-1:0]        pos_sum;
  logic                      out_free;
  logic                      report;
  logic [2:0]                compass;
  logic                      accept;

  gdr_sine_lookup #(
    .SINE_FRAC_BITS(SINE_FRAC_BITS)
  ) u_sine (
    .heading_i(heading_r),
    .mag_x_o  (mag_x),
    .neg_x_o  (neg_x),
    .mag_y_o  (mag_y),
    .neg_y_o  (neg_y)
  );

  assign accept    = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;
  assign mul_p     = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      S_MUL_YAW: begin
        mul_a = MUL_A_W'(rate_r);
        mul_b = $signed({9'd0, time_step_r});
      end
      S_MUL_HI: begin
        mul_a = $signed({1'b0, mag_r[63:32]});
        mul_b = $signed({9'd0, heading_gain_r});
      end
      S_MUL_LO: begin
        mul_a = $signed({1'b0, mag_r[31:0]});
        mul_b = $signed({9'd0, heading_gain_r});
      end
      S_MUL_X: begin
        mul_a = $signed(MUL_A_W'(mag_x));
        mul_b = $signed({1'b0, drive_step_r});
      end
      S_MUL_Y: begin
        mul_a = $signed(MUL_A_W'(mag_y));
        mul_b = $signed({1'b0, drive_step_r});
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_comb begin
    yaw_sum = YAW_EXT'(yaw_r) + YAW_EXT'(prod_r);
    yaw_abs = (yaw_r < 0) ? (64'd0 - 64'(yaw_r)) : 64'(yaw_r);

    // Restoring reduction of one byte against 360.
    mod_v = {rem_r, ip_r[IP_W-1 -: 8]};
    for (int i = 7; i >= 0; i--) begin
      if (mod_v >= (17'd360 << i)) begin
        mod_v = mod_v - (17'd360 << i);
      end
    end

    heading_calc = (yaw_r > 0 && rem_r != 9'd0) ? (DEG_360 - rem_r) : rem_r;

    step_mag = prod_r[SINE_FRAC_BITS +: STEP_W];
    step_ext = POS_EXT'(step_mag);
    if (state_r == S_MUL_Y) begin
      pos_base = pos_x_r;
      step_neg = neg_x;
    end else begin
      pos_base = pos_y_r;
      step_neg = !neg_y;
    end
    pos_sum = POS_EXT'(pos_base) + (step_neg ? (POS_EXT'(0) - step_ext) : step_ext);

    report  = tick_r >= report_period_r;
    compass = COMPASS_N;
    if (report) begin
      priority if (heading_r < DEG_45 || heading_r > DEG_315) begin
        compass = COMPASS_N;
      end else if (heading_r > DEG_45 && heading_r < DEG_135) begin
        compass = COMPASS_E;
      end else if (heading_r > DEG_135 && heading_r < DEG_225) begin
        compass = COMPASS_S;
      end else if (heading_r > DEG_225 && heading_r < DEG_315) begin
        compass = COMPASS_W;
      end else begin
        compass = COMPASS_NONE;
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    in_tready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          state_nxt = S_MUL_YAW;
        end
      end
      S_MUL_YAW: state_nxt = S_ADD_YAW;
      S_ADD_YAW: state_nxt = S_MAG;
      S_MAG:     state_nxt = S_MUL_HI;
      S_MUL_HI:  state_nxt = S_MUL_LO;
      S_MUL_LO:  state_nxt = S_IP;
      S_IP:      state_nxt = S_MOD;
      S_MOD: begin
        if (digit_r == 3'(IP_DIGITS - 1)) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD:    state_nxt = S_MUL_X;
      S_MUL_X:   state_nxt = S_MUL_Y;
      S_MUL_Y:   state_nxt = S_POS_Y;
      S_POS_Y:   state_nxt = S_DONE;
      S_DONE: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default:   state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      time_step_r     <= TIME_STEP_RST;
      heading_gain_r  <= HEADING_GAIN_RST;
      drive_step_r    <= DRIVE_STEP_RST;
      report_period_r <= REPORT_PERIOD_RST;
      yaw_r           <= '0;
      pos_x_r         <= start_load(START_X_RST);
      pos_y_r         <= start_load(START_Y_RST);
      tick_r          <= '0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_wen) begin
        unique case (cfg_index)
          REG_TIME_STEP:     time_step_r     <= cfg_wdata[15:0];
          REG_HEADING_GAIN:  heading_gain_r  <= cfg_wdata[15:0];
          REG_DRIVE_STEP:    drive_step_r    <= cfg_wdata;
          REG_START_X:       pos_x_r         <= start_load(cfg_wdata[15:0]);
          REG_START_Y:       pos_y_r         <= start_load(cfg_wdata[15:0]);
          REG_REPORT_PERIOD: report_period_r <= cfg_wdata[7:0];
          default: begin
          end
        endcase
      end
      if (state_r == S_ADD_YAW) begin
        yaw_r <= sat_yaw(yaw_sum);
      end
      if (state_r == S_MUL_Y && drive_r) begin
        pos_x_r <= sat_pos(pos_sum);
      end
      if (state_r == S_POS_Y && drive_r) begin
        pos_y_r <= sat_pos(pos_sum);
      end
      if (state_r == S_DONE && out_free) begin
        tick_r      <= report ? 8'd1 : (tick_r + 8'd1);
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_p;
    if (accept) begin
      rate_r  <= $signed(in_tdata[15:0]);
      drive_r <= in_tdata[16];
    end
    unique case (state_r)
      S_MAG:    mag_r <= yaw_abs;
      S_MUL_LO: ip_r  <= prod_r[IP_W-1:0];
      S_IP: begin
        ip_r    <= ip_r + IP_W'(prod_r[47:32]);
        rem_r   <= '0;
        digit_r <= '0;
      end
      S_MOD: begin
        rem_r   <= mod_v[8:0];
        ip_r    <= ip_r << 8;
        digit_r <= digit_r + 3'd1;
      end
      S_HEAD:   heading_r <= heading_calc;
      S_DONE: begin
        if (out_free) begin
          out_data_r <= {4'd0, compass, heading_r, pos_out(pos_y_r), pos_out(pos_x_r)};
          out_user_r <= report;
        end
      end
      default: begin
      end
    endcase
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_heading_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[40:32] < DEG_360)
    else $error("heading out of range");

  a_compass_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tdata[43:41] == COMPASS_N)
    else $error("compass set without report");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> !in_tready)
    else $error("ready right after accepting a word");

  a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_HEAD |-> rem_r < DEG_360)
    else $error("mod 360 remainder out of range");

  a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("result loaded outside the final step");
`endif

endmodule

@@ design/gdr_sine_lookup.sv @@
// Sine and cosine magnitude lookup for a whole-degree heading.
// Quarter-wave constant table built from gdr_pkg::gdr_sine_q30; depends on gdr_pkg.
module gdr_sine_lookup import gdr_pkg::*; #(
  parameter int SINE_FRAC_BITS = 16
) (
  input  logic [8:0]              heading_i,
  output logic [SINE_FRAC_BITS:0] mag_x_o,
  output logic                    neg_x_o,
  output logic [SINE_FRAC_BITS:0] mag_y_o,
  output logic                    neg_y_o
);

  localparam int SINE_W = SINE_FRAC_BITS + 1;
  localparam int SH     = 30 - SINE_FRAC_BITS;

  logic [SINE_W-1:0] sine_tab [0:90];
  logic [8:0]        angle_y;

  for (genvar k = 0; k <= 90; k++) begin : g_tab
    assign sine_tab[k] = SINE_W'((gdr_sine_q30(k) + (64'd1 << (SH - 1))) >> SH);
  end

  // The cosine is the sine of the heading plus a quarter turn.
  assign angle_y = (heading_i >= DEG_270) ? (heading_i - DEG_270) : (heading_i + DEG_90);

  assign mag_x_o = sine_tab[gdr_fold(heading_i)];
  assign neg_x_o = heading_i > DEG_180;
  assign mag_y_o = sine_tab[gdr_fold(angle_y)];
  assign neg_y_o = angle_y > DEG_180;

endmodule
